// ===== hw/rtl/csd_pkg.sv =====
`default_nettype none

package csd_pkg;

  localparam int unsigned CntW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CntW-1:0] PresenceThrReset = 8'd10;
  localparam logic [CntW-1:0] EndThrReset      = 8'd10;

  localparam logic [CfgIdxW-1:0] RegPresenceThr = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEndThr      = 1'd1;

  typedef enum logic [1:0] {
    ChargeUnknown  = 2'd0,
    ChargeCharging = 2'd1,
    ChargeFinished = 2'd2
  } charge_state_e;

  typedef struct packed {
    logic present_pin;
    logic end_pin;
  } in_t;

  typedef struct packed {
    charge_state_e charge_state;
    logic          charger_present;
    logic          presence_known;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] wdata;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csd_in_if.sv =====
`default_nettype none

interface csd_in_if;
  logic          valid;
  logic          ready;
  csd_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csd_out_if.sv =====
`default_nettype none

interface csd_out_if;
  logic          valid;
  logic          ready;
  csd_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csd_cfg_if.sv =====
`default_nettype none

interface csd_cfg_if;
  logic          valid;
  logic          ready;
  csd_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/charger_status_debouncer_core.sv =====
// Charger status debouncer: presence and charge-end qualification of two pin samples.
// Pipeline: the input register holds each sample, then the debounce state update
//   loads its status into the result register.
// Throughput: one sample per cycle while the result register is not stalled by out_o.ready.
// Reset (rst_ni low, asynchronous): all debounce state clears, thresholds return to 10.
`default_nettype none

module charger_status_debouncer_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  csd_in_if.sink       in_i,
  csd_out_if.source    out_o,
  csd_cfg_if.sink      cfg_i
);

  // Configuration registers; always ready. Writes must come only while idle; the block leaves this to the user.
  logic [csd_pkg::CntW-1:0] pres_thr_q, end_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_thr_q <= csd_pkg::PresenceThrReset;
      end_thr_q  <= csd_pkg::EndThrReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        csd_pkg::RegPresenceThr: pres_thr_q <= cfg_i.data.wdata;
        csd_pkg::RegEndThr:      end_thr_q  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: input register feeds the result register.
  logic         s1_valid_q;
  csd_pkg::in_t s1_data_q;
  logic         out_valid_q;
  csd_pkg::out_t out_data_q;
  logic         s2_ready, s1_ready, s2_fire;

  assign s2_ready = !out_valid_q || out_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s2_fire  = s1_valid_q && s2_ready;

  assign in_i.ready  = s1_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold the sample until the result stage takes it.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_data_q <= in_i.data;
    end
  end

  // Debounce state.
  logic                     primed_q, primed_d;
  logic                     pres_flag_q, pres_flag_d;
  logic                     pres_known_q, pres_known_d;
  logic [csd_pkg::CntW-1:0] pres_cnt_q, pres_cnt_d;
  logic                     end_flag_q, end_flag_d;
  logic                     end_known_q, end_known_d;
  logic [csd_pkg::CntW-1:0] chg_cnt_q, chg_cnt_d;
  logic [csd_pkg::CntW-1:0] end_cnt_q, end_cnt_d;
  csd_pkg::out_t            result_d;

  always_comb begin
    logic ppin, epin;
    logic [csd_pkg::CntW-1:0] inc;

    ppin = s1_data_q.present_pin;
    epin = s1_data_q.end_pin;

    primed_d     = 1'b1;
    pres_flag_d  = primed_q ? pres_flag_q : !ppin;  // prime on the first sample
    pres_known_d = pres_known_q;
    pres_cnt_d   = pres_cnt_q;
    end_flag_d   = end_flag_q;
    end_known_d  = end_known_q;
    chg_cnt_d    = chg_cnt_q;
    end_cnt_d    = end_cnt_q;
    inc          = '0;

    // Presence: flip after enough consecutive disagreeing samples.
    if (pres_flag_d == ppin) begin
      pres_cnt_d = '0;
    end else begin
      pres_cnt_d = pres_cnt_q + 8'd1;
      if (pres_cnt_d >= pres_thr_q) begin
        pres_cnt_d   = '0;
        pres_flag_d  = !pres_flag_d;
        pres_known_d = 1'b1;
      end
    end

    if (pres_known_d) begin
      if (pres_flag_d) begin
        if (epin == end_flag_q) begin
          // Pin agrees with the held end flag: clear the opposing counter and qualify an unknown end state.
          if (end_flag_q) chg_cnt_d = '0;
          else            end_cnt_d = '0;
          if (end_known_q) begin
            if (end_flag_q) end_cnt_d = '0;
            else            chg_cnt_d = '0;
          end else if (end_flag_q) begin
            inc = end_cnt_d + 8'd1;
            end_cnt_d = inc;
            if (inc >= end_thr_q) begin
              end_cnt_d   = '0;
              end_known_d = 1'b1;
            end
          end else begin
            inc = chg_cnt_d + 8'd1;
            chg_cnt_d = inc;
            if (inc >= end_thr_q) begin
              chg_cnt_d   = '0;
              end_known_d = 1'b1;
            end
          end
        end else if (end_flag_q) begin
          // Charge end dropped: qualify a return to charging.
          end_cnt_d = '0;
          inc = chg_cnt_q + 8'd1;
          chg_cnt_d = inc;
          if (inc >= end_thr_q) begin
            chg_cnt_d   = '0;
            end_flag_d  = 1'b0;
            end_known_d = 1'b1;
          end
        end else begin
          // Charge end asserted: qualify finished.
          chg_cnt_d = '0;
          inc = end_cnt_q + 8'd1;
          end_cnt_d = inc;
          if (inc >= end_thr_q) begin
            end_cnt_d   = '0;
            end_flag_d  = 1'b1;
            end_known_d = 1'b1;
          end
        end
      end else begin
        // Charger known absent: drop end detection, keep the end counter.
        end_flag_d  = 1'b0;
        end_known_d = 1'b0;
        chg_cnt_d   = '0;
      end
    end

    result_d.charge_state    = csd_pkg::ChargeUnknown;
    if (pres_known_d && pres_flag_d && end_known_d) begin
      result_d.charge_state  = end_flag_d ? csd_pkg::ChargeFinished : csd_pkg::ChargeCharging;
    end
    result_d.charger_present = pres_flag_d;
    result_d.presence_known  = pres_known_d;
  end

  // Advance state only when a sample moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      pres_flag_q  <= 1'b0;
      pres_known_q <= 1'b0;
      pres_cnt_q   <= '0;
      end_flag_q   <= 1'b0;
      end_known_q  <= 1'b0;
      chg_cnt_q    <= '0;
      end_cnt_q    <= '0;
    end else if (s2_fire) begin
      primed_q     <= primed_d;
      pres_flag_q  <= pres_flag_d;
      pres_known_q <= pres_known_d;
      pres_cnt_q   <= pres_cnt_d;
      end_flag_q   <= end_flag_d;
      end_known_q  <= end_known_d;
      chg_cnt_q    <= chg_cnt_d;
      end_cnt_q    <= end_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_data_q <= result_d;
    end
  end

  // Checks.
  a_state_needs_presence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.charge_state != csd_pkg::ChargeUnknown)
      |-> (out_data_q.charger_present && out_data_q.presence_known))
    else $error("charge state reported without known presence");

  a_known_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pres_known_q |=> pres_known_q)
    else $error("presence known dropped");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_data_q))
    else $error("input stage lost a stalled sample");

  a_absent_clears_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && pres_known_d && !pres_flag_d |=> !end_known_q && (chg_cnt_q == '0))
    else $error("end detection kept while charger absent");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // No transfer on any channel for this many cycles ends the run.
  localparam int unsigned StallLimit = 4000;
  // Cycles to let pass once nothing is expected.
  localparam int unsigned SettleCycles = 6;
  // Length of the one long receiver hold-off that backs up the pipeline.
  localparam int unsigned LongHold = 300;
  localparam int unsigned NumPhases = 7;

  // Predicts the debounced charger status for every accepted pin sample
  // and checks the block's results against it in order.
  class status_scoreboard;
    logic [csd_pkg::CntW-1:0] pres_thr;
    logic [csd_pkg::CntW-1:0] end_thr;
    logic                     primed;
    logic                     pres_flag;
    logic                     pres_known;
    logic [csd_pkg::CntW-1:0] pres_cnt;
    logic                     end_flag;
    logic                     end_known;
    logic [csd_pkg::CntW-1:0] chg_cnt;
    logic [csd_pkg::CntW-1:0] end_cnt;
    csd_pkg::out_t            expected_status[$];
    int unsigned              errors;
    int unsigned              checked;

    function new();
      pres_thr   = csd_pkg::PresenceThrReset;
      end_thr    = csd_pkg::EndThrReset;
      primed     = 1'b0;
      pres_flag  = 1'b0;
      pres_known = 1'b0;
      pres_cnt   = '0;
      end_flag   = 1'b0;
      end_known  = 1'b0;
      chg_cnt    = '0;
      end_cnt    = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    task report(string msg);
      if (errors < 100) begin
        $display("ERROR: %s", msg);
      end
      errors++;
    endtask

    function void set_threshold(logic [csd_pkg::CfgIdxW-1:0] idx,
                                logic [csd_pkg::CfgDatW-1:0] val);
      case (idx)
        csd_pkg::RegPresenceThr: pres_thr = val;
        csd_pkg::RegEndThr:      end_thr  = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // Advance the debounce state by one sample and queue the status it yields.
    function void note_sample(csd_pkg::in_t s);
      csd_pkg::out_t r;
      logic ppin;
      logic epin;
      ppin = s.present_pin;
      epin = s.end_pin;
      // First sample after reset: start from the opposite of the pin.
      if (!primed) begin
        pres_flag = ~ppin;
        primed    = 1'b1;
      end
      if (pres_flag == ppin) begin
        pres_cnt = '0;
      end else begin
        pres_cnt = pres_cnt + 8'd1;
        if (pres_cnt >= pres_thr) begin
          pres_cnt   = '0;
          pres_flag  = ~pres_flag;
          pres_known = 1'b1;
        end
      end
      r.charge_state = csd_pkg::ChargeUnknown;
      if (pres_known) begin
        if (pres_flag) begin
          if (epin == end_flag) begin
            if (end_flag) chg_cnt = '0;
            else end_cnt = '0;
            if (end_known) begin
              if (end_flag) end_cnt = '0;
              else chg_cnt = '0;
            end else if (end_flag) begin
              end_cnt = end_cnt + 8'd1;
              if (end_cnt >= end_thr) begin
                end_cnt   = '0;
                end_known = 1'b1;
              end
            end else begin
              chg_cnt = chg_cnt + 8'd1;
              if (chg_cnt >= end_thr) begin
                chg_cnt   = '0;
                end_known = 1'b1;
              end
            end
          end else if (end_flag) begin
            end_cnt = '0;
            chg_cnt = chg_cnt + 8'd1;
            if (chg_cnt >= end_thr) begin
              chg_cnt   = '0;
              end_flag  = 1'b0;
              end_known = 1'b1;
            end
          end else begin
            chg_cnt = '0;
            end_cnt = end_cnt + 8'd1;
            if (end_cnt >= end_thr) begin
              end_cnt   = '0;
              end_flag  = 1'b1;
              end_known = 1'b1;
            end
          end
          if (end_known) begin
            r.charge_state = end_flag ? csd_pkg::ChargeFinished : csd_pkg::ChargeCharging;
          end
        end else begin
          // Charger known absent: forget charge-end detection, keep end_cnt.
          end_flag  = 1'b0;
          end_known = 1'b0;
          chg_cnt   = '0;
        end
      end
      r.charger_present = pres_flag;
      r.presence_known  = pres_known;
      expected_status.push_back(r);
    endfunction

    task check_status(csd_pkg::out_t got);
      csd_pkg::out_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected: %p", checked, got));
        checked++;
        return;
      end
      want = expected_status.pop_front();
      if (got.charge_state !== want.charge_state) begin
        report($sformatf("result %0d charge_state %0d, expected %0d", checked,
                         got.charge_state, want.charge_state));
      end
      if (got.charger_present !== want.charger_present) begin
        report($sformatf("result %0d charger_present %b, expected %b", checked,
                         got.charger_present, want.charger_present));
      end
      if (got.presence_known !== want.presence_known) begin
        report($sformatf("result %0d presence_known %b, expected %b", checked,
                         got.presence_known, want.presence_known));
      end
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_n;

  csd_in_if  in_if();
  csd_out_if out_if();
  csd_cfg_if cfg_if();

  charger_status_debouncer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  status_scoreboard sb;

  // Sender burst bookkeeping, shared across calls of push_sample.
  int unsigned burst_left;
  // Raised by the stimulus to ask the receiver for its long hold-off.
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one pin sample and hold it until the block takes it. Samples go
  // out in bursts; a random gap (sometimes none) opens each new burst.
  task automatic push_sample(input csd_pkg::in_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(s);
    burst_left--;
  endtask

  // Write both thresholds back to back; valid stays high across the pair
  // and drops only after the second transfer.
  task automatic write_thresholds(input logic [csd_pkg::CfgDatW-1:0] pthr,
                                  input logic [csd_pkg::CfgDatW-1:0] ethr);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: csd_pkg::RegPresenceThr, wdata: pthr};
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_threshold(csd_pkg::RegPresenceThr, pthr);
    cfg_if.data  <= '{index: csd_pkg::RegEndThr, wdata: ethr};
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_threshold(csd_pkg::RegEndThr, ethr);
    cfg_if.valid <= 1'b0;
  endtask

  // Check every result transfer at the edge where it happens.
  always @(posedge clk_i) begin
    if (rst_n === 1'b1 && out_if.valid && out_if.ready) begin
      sb.check_status(out_if.data);
    end
  end

  // Receiver: switch between always ready, random stalls and a fixed
  // on/off pattern; serve the long hold-off when asked, counting its cycles
  // here so the sender keeps offering and the input backs up.
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned per;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(8, 64);
        per  = $urandom_range(1, 5);
        for (int k = 0; k < seg; k++) begin
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= (((k / per) % 2) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved anything for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("ERROR: no transfer for %0d cycles", StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    csd_pkg::in_t                s;
    int unsigned                 pthr_list[NumPhases];
    int unsigned                 ethr_list[NumPhases];
    int unsigned                 cnt_list[NumPhases];
    int unsigned                 pthr;
    int unsigned                 ethr;
    int unsigned                 p_left;
    int unsigned                 e_left;
    logic                        p_lvl;
    logic                        e_lvl;
    logic [csd_pkg::CfgDatW-1:0] pthr_cfg;
    logic [csd_pkg::CfgDatW-1:0] ethr_cfg;

    sb         = new();
    burst_left = 0;
    hold_req   = 1'b0;

    // Phases: shortest thresholds, longest thresholds, zero on either side,
    // two random mid settings and finally the reset value written back.
    pthr_list = '{1, 255, 0, 5, 0, 0, 10};
    ethr_list = '{1, 255, 3, 0, 0, 0, 10};
    cnt_list  = '{150, 800, 150, 150, 150, 150, 100};
    for (int i = 4; i < 6; i++) begin
      pthr_list[i] = $urandom_range(2, 30);
      ethr_list[i] = $urandom_range(2, 30);
    end

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset thresholds. The first sample primes the
    // presence flag low; the charger then qualifies after ten samples and
    // the end pin reaches "finished" ten samples on.
    s.present_pin = 1'b1;
    s.end_pin     = 1'b1;
    for (int i = 0; i < 19; i++) begin
      push_sample(s);
    end
    // Drop the end pin briefly, then glitch presence low: neither qualifies.
    s.end_pin = 1'b0;
    push_sample(s);
    push_sample(s);
    s.present_pin = 1'b0;
    s.end_pin     = 1'b1;
    push_sample(s);
    push_sample(s);
    s.present_pin = 1'b1;
    push_sample(s);
    s.present_pin = 1'b0;
    s.end_pin     = 1'b0;
    push_sample(s);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Quiesce before touching the thresholds.
      in_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      pthr = pthr_list[ph];
      ethr = ethr_list[ph];
      pthr_cfg = pthr[csd_pkg::CfgDatW-1:0];
      ethr_cfg = ethr[csd_pkg::CfgDatW-1:0];
      write_thresholds(pthr_cfg, ethr_cfg);
      // Back up the pipeline once, during the slow phase.
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      burst_left = 0;
      p_left     = 0;
      e_left     = 0;
      p_lvl      = 1'b0;
      e_lvl      = 1'b0;
      // Each pin holds a level for a run; about half the runs outlast the
      // threshold so presence and charge end do qualify, the rest are cut
      // short. Occasional single-sample glitches land on top.
      for (int n = 0; n < cnt_list[ph]; n++) begin
        if (p_left == 0) begin
          p_lvl  = ($urandom_range(0, 1) != 0);
          p_left = $urandom_range(0, 1) ? $urandom_range(pthr + 1, pthr + pthr / 2 + 2)
                                        : $urandom_range(1, pthr + 1);
        end
        if (e_left == 0) begin
          e_lvl  = ($urandom_range(0, 1) != 0);
          e_left = $urandom_range(0, 1) ? $urandom_range(ethr + 1, ethr + ethr / 2 + 2)
                                        : $urandom_range(1, ethr + 1);
        end
        s.present_pin = p_lvl;
        s.end_pin     = e_lvl;
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) != 0) s.present_pin = ~s.present_pin;
          else s.end_pin = ~s.end_pin;
        end
        p_left--;
        e_left--;
        push_sample(s);
      end
    end

    // Drain: wait for every expected status, then a few more cycles so a
    // stray extra result would still be caught.
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
